// ===== rtl/core/hsn_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-shell neighbor package
// Shared payload types, status and register codes, and offset tables.
// ----------------------------------------------------------------------------
package hsn_pkg;

    localparam int COUNT_W = 7;
    localparam int COORD_W = 6;
    localparam int INDEX_W = 18;
    localparam int SLOT_W  = 4;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_SMALL     = 2'd1;
    localparam status_t STATUS_UNCOVERED = 2'd2;
    localparam status_t STATUS_RANGE     = 2'd3;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_CELLS_X = 2'd0;
    localparam cfg_index_t CFG_CELLS_Y = 2'd1;
    localparam cfg_index_t CFG_CELLS_Z = 2'd2;

    typedef logic signed [1:0] off_t;
    localparam off_t OP = 2'sb01;
    localparam off_t ZR = 2'sb00;
    localparam off_t MN = 2'sb11;

    typedef struct packed {
        off_t dx;
        off_t dy;
        off_t dz;
    } off3_t;

    typedef struct packed {
        off_t da;
        off_t db;
    } off2_t;

    localparam off3_t FULL_OFF [13] = '{
        '{OP, OP, OP}, '{OP, ZR, OP}, '{OP, MN, OP}, '{ZR, OP, OP}, '{ZR, ZR, OP},
        '{ZR, MN, OP}, '{MN, OP, OP}, '{MN, ZR, OP}, '{MN, MN, OP}, '{OP, OP, ZR},
        '{OP, ZR, ZR}, '{OP, MN, ZR}, '{ZR, OP, ZR}
    };

    localparam off2_t PLANE_OFF [4] = '{'{OP, OP}, '{OP, ZR}, '{OP, MN}, '{ZR, OP}};

    localparam off2_t LAYER_OFF [9] = '{
        '{OP, OP}, '{OP, ZR}, '{OP, MN},
        '{ZR, OP}, '{ZR, ZR}, '{ZR, MN},
        '{MN, OP}, '{MN, ZR}, '{MN, MN}
    };

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
    } hsn_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbor_cell;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        status_t            status;
    } hsn_out_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        off3_t              off;
        logic [COUNT_W-1:0] nx;
        logic [COUNT_W-1:0] ny;
        logic [COUNT_W-1:0] nz;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        status_t            status;
    } hsn_job_t;

endpackage

// ===== rtl/core/hsn_index.sv =====
// ----------------------------------------------------------------------------
// Half-shell neighbor index pipeline
// Wraps the neighbor coordinates and forms x*ny*nz + y*nz + z in three stages.
// ----------------------------------------------------------------------------
module hsn_index
    import hsn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  hsn_job_t job,
    output logic     advance,
    output logic     result_valid,
    input  logic     result_stall,
    output hsn_out_t result
);

    typedef struct packed {
        logic [COUNT_W-1:0]   wx;
        logic [COUNT_W-1:0]   wy;
        logic [COUNT_W-1:0]   wz;
        logic [2*COUNT_W-1:0] nyz;
        logic [COUNT_W-1:0]   nz;
        logic [SLOT_W-1:0]    slot;
        logic                 last;
        status_t              status;
    } p1_t;

    typedef struct packed {
        logic [3*COUNT_W-1:0] px;
        logic [2*COUNT_W-1:0] py;
        logic [COUNT_W-1:0]   wz;
        logic [SLOT_W-1:0]    slot;
        logic                 last;
        status_t              status;
    } p2_t;

    function automatic logic [COUNT_W-1:0] wrap(logic [COORD_W-1:0] c, off_t d,
                                                 logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] ce;
        logic [COUNT_W-1:0] r;
        ce = {1'b0, c};
        if (d == OP) begin
            r = ((ce + 7'd1) >= n) ? 7'd0 : ce + 7'd1;
        end else if (d == MN) begin
            r = (ce == 7'd0) ? n - 7'd1 : ce - 7'd1;
        end else begin
            r = ce;
        end
        return r;
    endfunction

    logic     p1_valid_reg, p2_valid_reg, out_valid_reg;
    p1_t      p1_reg, p1_next;
    p2_t      p2_reg, p2_next;
    hsn_out_t out_reg, out_next;
    logic [3*COUNT_W-1:0] sum;

    assign advance      = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        p1_next.wx     = wrap(job.cx, job.off.dx, job.nx);
        p1_next.wy     = wrap(job.cy, job.off.dy, job.ny);
        p1_next.wz     = wrap(job.cz, job.off.dz, job.nz);
        p1_next.nyz    = job.ny * job.nz;
        p1_next.nz     = job.nz;
        p1_next.slot   = job.slot;
        p1_next.last   = job.last;
        p1_next.status = job.status;

        p2_next.px     = p1_reg.wx * p1_reg.nyz;
        p2_next.py     = p1_reg.wy * p1_reg.nz;
        p2_next.wz     = p1_reg.wz;
        p2_next.slot   = p1_reg.slot;
        p2_next.last   = p1_reg.last;
        p2_next.status = p1_reg.status;

        sum = p2_reg.px + {{COUNT_W{1'b0}}, p2_reg.py} + {{2*COUNT_W{1'b0}}, p2_reg.wz};
        out_next.neighbor_cell = (p2_reg.status == STATUS_OK) ? sum[INDEX_W-1:0]
                                                              : '0;
        out_next.slot   = p2_reg.slot;
        out_next.last   = p2_reg.last;
        out_next.status = p2_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg  <= job.valid;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/half_shell_neighbor_cell_generator.sv =====
// ----------------------------------------------------------------------------
// Half-shell neighbor cell generator
// Expands one home cell into its periodic half-shell neighbor cell indices.
//
// Channel  | Direction | Handshake            | Payload
// item     | in        | item_valid/stall     | hsn_in_t (cell_x, cell_y, cell_z)
// result   | out       | result_valid/stall   | hsn_out_t (neighbor_cell, slot, ...)
// cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (cell counts)
//
// Each item yields 1, 4 or 13 results, one per cycle while the result channel
// does not stall; the next item is taken in the cycle its predecessor issues
// its last result. Reset empties the pipeline and sets all cell counts to 4.
// A result stall while a result is valid holds the whole pipeline in place.
// ----------------------------------------------------------------------------
module half_shell_neighbor_cell_generator
    import hsn_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  hsn_in_t            item,
    output logic               result_valid,
    input  logic               result_stall,
    output hsn_out_t           result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] cells_x_reg, cells_y_reg, cells_z_reg;
    logic [COUNT_W-1:0] nx, ny, nz;
    logic               small_grid, full, plane0, plane1, plane2, uncovered, out_of_range;
    logic [1:0]         axis_next;
    logic               stack;
    logic [COORD_W-1:0] layer_coord;
    status_t            status_next;
    logic [SLOT_W-1:0]  last_slot_next;

    logic               busy_reg;
    hsn_in_t            cur_reg;
    status_t            status_reg;
    logic               full_reg;
    logic [1:0]         axis_reg;
    logic [SLOT_W-1:0]  slot_reg, last_slot_reg;

    logic               advance, accept, issue_last;
    off3_t              off;
    off2_t              in_plane;
    off_t               layer_off;
    hsn_job_t           job;

    function automatic logic [COUNT_W-1:0] eff_count(logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (int'(v) > MAX_CELLS_PER_AXIS) begin
            r = COUNT_W'(MAX_CELLS_PER_AXIS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cells_x_reg <= 7'd4;
            cells_y_reg <= 7'd4;
            cells_z_reg <= 7'd4;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CELLS_X: cells_x_reg <= cfg_data;
                CFG_CELLS_Y: cells_y_reg <= cfg_data;
                CFG_CELLS_Z: cells_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        nx = eff_count(cells_x_reg);
        ny = eff_count(cells_y_reg);
        nz = eff_count(cells_z_reg);

        small_grid = (nx < 7'd4) && (ny < 7'd4) && (nz < 7'd4);
        full       = (nx > 7'd2) && (ny > 7'd2) && (nz > 7'd2);
        plane0     = (ny > 7'd2) && (nz > 7'd2) && ((nx == 7'd1) || (nx == 7'd2));
        plane1     = (nz > 7'd2) && (nx > 7'd2) && ((ny == 7'd1) || (ny == 7'd2));
        plane2     = (nx > 7'd2) && (ny > 7'd2) && ((nz == 7'd1) || (nz == 7'd2));
        uncovered  = !full && !plane0 && !plane1 && !plane2;

        if (plane2) begin
            axis_next   = 2'd2;
            stack       = (nz == 7'd2);
            layer_coord = item.cell_z;
        end else if (plane1) begin
            axis_next   = 2'd1;
            stack       = (ny == 7'd2);
            layer_coord = item.cell_y;
        end else begin
            axis_next   = 2'd0;
            stack       = plane0 && (nx == 7'd2);
            layer_coord = item.cell_x;
        end

        out_of_range = ({1'b0, item.cell_x} >= nx) || ({1'b0, item.cell_y} >= ny) ||
                       ({1'b0, item.cell_z} >= nz);

        if (small_grid) begin
            status_next = STATUS_SMALL;
        end else if (uncovered) begin
            status_next = STATUS_UNCOVERED;
        end else if (out_of_range) begin
            status_next = STATUS_RANGE;
        end else begin
            status_next = STATUS_OK;
        end

        if (status_next != STATUS_OK) begin
            last_slot_next = 4'd0;
        end else if (full || (stack && (layer_coord == '0))) begin
            last_slot_next = 4'd12;
        end else begin
            last_slot_next = 4'd3;
        end
    end

    assign issue_last = busy_reg && (slot_reg == last_slot_reg);
    assign item_stall = busy_reg && !(advance && issue_last);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
        end else if (advance && issue_last) begin
            busy_reg <= 1'b0;
        end else if (advance && busy_reg) begin
            slot_reg <= slot_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cur_reg       <= item;
            status_reg    <= status_next;
            full_reg      <= full;
            axis_reg      <= axis_next;
            last_slot_reg <= last_slot_next;
        end
    end

    always_comb
    begin
        if (slot_reg < 4'd4) begin
            in_plane  = PLANE_OFF[slot_reg[1:0]];
            layer_off = ZR;
        end else begin
            in_plane  = LAYER_OFF[slot_reg - 4'd4];
            layer_off = OP;
        end

        if (full_reg) begin
            off = FULL_OFF[slot_reg];
        end else begin
            case (axis_reg)
                2'd0:    off = '{layer_off, in_plane.da, in_plane.db};
                2'd1:    off = '{in_plane.da, layer_off, in_plane.db};
                default: off = '{in_plane.da, in_plane.db, layer_off};
            endcase
        end

        job.valid  = busy_reg;
        job.cx     = cur_reg.cell_x;
        job.cy     = cur_reg.cell_y;
        job.cz     = cur_reg.cell_z;
        job.off    = off;
        job.nx     = nx;
        job.ny     = ny;
        job.nz     = nz;
        job.slot   = slot_reg;
        job.last   = issue_last;
        job.status = status_reg;
    end

    hsn_index u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
